// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ccr_pkg.sv
package ccr_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ENTRY_W = 5;

  // Operation codes
  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Colour spec kinds; the unused code falls back to default
  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_INDEX   = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  // Fixed palette entries
  localparam logic [ENTRY_W-1:0] ENTRY_INK   = 5'd16;
  localparam logic [ENTRY_W-1:0] ENTRY_PAPER = 5'd17;

  // Configuration register indexes
  localparam logic [1:0] CFG_LIGHT_COLORS   = 2'd0;
  localparam logic [1:0] CFG_INTENSIFY_BOLD = 2'd1;
  localparam logic [1:0] CFG_REVERSE_SCREEN = 2'd2;
  localparam logic [1:0] CFG_LINKS_ENABLED  = 2'd3;

  typedef logic [COLOR_W-1:0] rgb_t;

  // Palette write transfer
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
    rgb_t               data;
  } pal_wr_t;

  // Palette read request, one address per colour
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] ink_addr;
    logic [ENTRY_W-1:0] paper_addr;
  } pal_rd_t;

  // Power-up palette contents; entries past the standard set are black
  function automatic rgb_t reset_color(logic [ENTRY_W-1:0] idx);
    rgb_t c;
    unique case (idx)
      5'd0:    c = 24'h000000;
      5'd1:    c = 24'h800000;
      5'd2:    c = 24'h008000;
      5'd3:    c = 24'h808000;
      5'd4:    c = 24'h000080;
      5'd5:    c = 24'h800080;
      5'd6:    c = 24'h008080;
      5'd7:    c = 24'hFFFFFF;
      5'd8:    c = 24'h000000;
      5'd9:    c = 24'hFF0000;
      5'd10:   c = 24'h00FF00;
      5'd11:   c = 24'hFFFF00;
      5'd12:   c = 24'h0000FF;
      5'd13:   c = 24'hFF00FF;
      5'd14:   c = 24'h00FFFF;
      5'd15:   c = 24'hFFFFFF;
      5'd16:   c = 24'h000000;
      5'd17:   c = 24'hFFFFFF;
      5'd18:   c = 24'hFFFFFF;
      5'd19:   c = 24'h000080;
      5'd20:   c = 24'h808000;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// File: sv/ccr_palette.sv
`include "assert_macros.svh"

module ccr_palette #(
  parameter int unsigned PALETTE_SIZE = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ccr_pkg::pal_wr_t  wr_i,
  input  ccr_pkg::pal_rd_t  rd_i,
  output ccr_pkg::rgb_t     ink_data_o,
  output ccr_pkg::rgb_t     paper_data_o
);

  localparam int unsigned AW = $clog2(PALETTE_SIZE);

  ccr_pkg::rgb_t           mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] valid_r;
  ccr_pkg::rgb_t           ink_data_r;
  ccr_pkg::rgb_t           paper_data_r;

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] ink_addr;
  logic [AW-1:0] paper_addr;

  assign wr_addr    = wr_i.addr[AW-1:0];
  assign ink_addr   = rd_i.ink_addr[AW-1:0];
  assign paper_addr = rd_i.paper_addr[AW-1:0];

  // Storage: one write port, no reset on the array itself
  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.data;
    end
  end

  // Written marks; an unmarked entry reads as its power-up colour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_i.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk) begin
    if (rd_i.en) begin
      ink_data_r   <= valid_r[ink_addr] ? mem[ink_addr]
                                        : ccr_pkg::reset_color(rd_i.ink_addr);
      paper_data_r <= valid_r[paper_addr] ? mem[paper_addr]
                                          : ccr_pkg::reset_color(rd_i.paper_addr);
    end
  end

  assign ink_data_o   = ink_data_r;
  assign paper_data_o = paper_data_r;

  `ASSERT_CLK(a_wr_marks_valid, wr_i.en |=> valid_r[$past(wr_addr)], "palette write not marked")

endmodule

// File: sv/cell_color_resolver.sv
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+----------------------------
// input    | start, busy, in_*                       | start & !busy at rising edge
// result   | out_valid, out_ink_rgb, out_paper_rgb   | out_valid, one cycle each
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One item per cycle while busy is low; a resolve result passes through stage 1
// (palette read and cube/grey mapping), then dimming and swap into the output register.
// A palette write takes effect for the very next item. Write items give no result.
// Reset is synchronous; busy is high for the first cycle out of reset only.
// The receiver cannot stall, so only busy out of reset holds the input back.
`include "assert_macros.svh"

module cell_color_resolver #(
  parameter int unsigned PALETTE_SIZE = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [1:0]                    in_ink_kind,
  input  logic [ccr_pkg::COLOR_W-1:0]   in_ink_value,
  input  logic [1:0]                    in_paper_kind,
  input  logic [ccr_pkg::COLOR_W-1:0]   in_paper_value,
  input  logic                          in_inverted,
  input  logic                          in_faint,
  input  logic                          in_bold,
  input  logic                          in_link_active,
  input  logic [ccr_pkg::ENTRY_W-1:0]   in_entry_index,
  input  logic [ccr_pkg::COLOR_W-1:0]   in_entry_color,
  // result channel
  output logic                          out_valid,
  output logic [ccr_pkg::COLOR_W-1:0]   out_ink_rgb,
  output logic [ccr_pkg::COLOR_W-1:0]   out_paper_rgb,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic                          cfg_data
);

  // Palette address for a spec; only a low index reaches the palette
  function automatic logic [ccr_pkg::ENTRY_W-1:0] pal_addr(
    logic [1:0] kind, logic [7:0] idx, logic lift, logic [ccr_pkg::ENTRY_W-1:0] dflt);
    logic [ccr_pkg::ENTRY_W-1:0] a;
    a = dflt;
    if (kind == ccr_pkg::KIND_INDEX) begin
      a = {1'b0, idx[3:0]};
      if (lift && !idx[3]) begin
        a = {2'b01, idx[2:0]};
      end
    end
    return a;
  endfunction

  function automatic logic [7:0] cube_step(logic [2:0] s);
    return (s == 3'd0) ? 8'd0 : 8'(8'd55 + 8'(s) * 8'd40);
  endfunction

  // 6x6x6 cube: divide by 36 and 6 through reciprocal multiplies
  function automatic ccr_pkg::rgb_t cube_color(logic [7:0] idx);
    logic [7:0]  v;
    logic [15:0] p36;
    logic [2:0]  q36;
    logic [5:0]  r36;
    logic [15:0] p6;
    logic [2:0]  q6;
    logic [2:0]  r6;
    v   = idx - 8'd16;
    p36 = 16'(v) * 16'd57;
    q36 = p36[13:11];
    r36 = 6'(v - 8'(q36) * 8'd36);
    p6  = 16'(r36) * 16'd43;
    q6  = p6[10:8];
    r6  = 3'(r36 - 6'(q6) * 6'd6);
    return {cube_step(q36), cube_step(q6), cube_step(r6)};
  endfunction

  function automatic ccr_pkg::rgb_t grey_color(logic [7:0] idx);
    logic [7:0] g;
    g = 8'((idx - 8'd232) * 8'd10 + 8'd8);
    return {g, g, g};
  endfunction

  // Colour of a spec that does not go through the palette
  function automatic ccr_pkg::rgb_t resolve(logic [1:0] kind, ccr_pkg::rgb_t value);
    ccr_pkg::rgb_t c;
    c = '0;
    if (kind == ccr_pkg::KIND_RGB) begin
      c = value;
    end else if (kind == ccr_pkg::KIND_INDEX) begin
      if (value[7:0] >= 8'd232) begin
        c = grey_color(value[7:0]);
      end else if (value[7:0] >= 8'd16) begin
        c = cube_color(value[7:0]);
      end
    end
    return c;
  endfunction

  // Default, unused kind and low indexes take the palette entry
  function automatic logic from_palette(logic [1:0] kind, logic [7:0] idx);
    return !((kind == ccr_pkg::KIND_RGB)
             || ((kind == ccr_pkg::KIND_INDEX) && (idx >= 8'd16)));
  endfunction

  // c - ceil(c * 77 / 256)
  function automatic logic [7:0] dim_channel(logic [7:0] c);
    logic [15:0] p;
    p = 16'(c) * 16'd77 + 16'd255;
    return c - p[15:8];
  endfunction

  // Configuration registers
  logic light_colors_r;
  logic intensify_bold_r;
  logic reverse_screen_r;
  logic links_enabled_r;

  // Control and pipeline registers
  logic busy_r;
  logic s1_valid_r;
  logic out_valid_r;

  // Stage 1 payload
  ccr_pkg::rgb_t  s1_ink_map_r;
  logic           s1_ink_pal_r;
  ccr_pkg::rgb_t  s1_paper_map_r;
  logic           s1_paper_pal_r;
  logic           s1_faint_r;
  logic           s1_swap_r;

  // Output payload
  ccr_pkg::rgb_t  out_ink_rgb_r;
  ccr_pkg::rgb_t  out_paper_rgb_r;
  ccr_pkg::rgb_t  out_ink_rgb_nxt;
  ccr_pkg::rgb_t  out_paper_rgb_nxt;

  logic             accept;
  logic             ink_lift;
  ccr_pkg::pal_wr_t pal_wr;
  ccr_pkg::pal_rd_t pal_rd;
  ccr_pkg::rgb_t    pal_ink;
  ccr_pkg::rgb_t    pal_paper;
  ccr_pkg::rgb_t    ink_res;
  ccr_pkg::rgb_t    ink_dim;
  ccr_pkg::rgb_t    paper_res;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_colors_r   <= 1'b0;
      intensify_bold_r <= 1'b0;
      reverse_screen_r <= 1'b0;
      links_enabled_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccr_pkg::CFG_LIGHT_COLORS:   light_colors_r   <= cfg_data;
        ccr_pkg::CFG_INTENSIFY_BOLD: intensify_bold_r <= cfg_data;
        ccr_pkg::CFG_REVERSE_SCREEN: reverse_screen_r <= cfg_data;
        ccr_pkg::CFG_LINKS_ENABLED:  links_enabled_r  <= cfg_data;
        default:                     light_colors_r   <= light_colors_r;
      endcase
    end
  end

  // Palette requests at the input transfer
  assign ink_lift = light_colors_r || (intensify_bold_r && in_bold);

  always_comb begin
    pal_wr.en   = accept && (in_operation == ccr_pkg::OP_WRITE)
                  && (32'(in_entry_index) < PALETTE_SIZE);
    pal_wr.addr = in_entry_index;
    pal_wr.data = in_entry_color;

    pal_rd.en         = accept && (in_operation == ccr_pkg::OP_RESOLVE);
    pal_rd.ink_addr   = pal_addr(in_ink_kind, in_ink_value[7:0], ink_lift,
                                 ccr_pkg::ENTRY_INK);
    pal_rd.paper_addr = pal_addr(in_paper_kind, in_paper_value[7:0], light_colors_r,
                                 ccr_pkg::ENTRY_PAPER);
  end

  ccr_palette #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_palette (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_i         (pal_wr),
    .rd_i         (pal_rd),
    .ink_data_o   (pal_ink),
    .paper_data_o (pal_paper)
  );

  // Control: busy for one cycle out of reset, valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s1_valid_r  <= pal_rd.en;
      out_valid_r <= s1_valid_r;
    end
  end

  // Stage 1 payload: cube, grey and direct colours mapped alongside the palette read
  always_ff @(posedge clk) begin
    if (pal_rd.en) begin
      s1_ink_map_r   <= resolve(in_ink_kind, in_ink_value);
      s1_ink_pal_r   <= from_palette(in_ink_kind, in_ink_value[7:0]);
      s1_paper_map_r <= resolve(in_paper_kind, in_paper_value);
      s1_paper_pal_r <= from_palette(in_paper_kind, in_paper_value[7:0]);
      s1_faint_r     <= in_faint;
      s1_swap_r      <= in_inverted ^ reverse_screen_r
                        ^ (links_enabled_r && in_link_active);
    end
  end

  // Stage 2: pick palette or mapped colour, dim faint ink, swap on the XOR of inversion, reverse screen and active link
  always_comb begin
    ink_res   = s1_ink_pal_r ? pal_ink : s1_ink_map_r;
    paper_res = s1_paper_pal_r ? pal_paper : s1_paper_map_r;
    ink_dim   = ink_res;
    if (s1_faint_r) begin
      ink_dim = {dim_channel(ink_res[23:16]), dim_channel(ink_res[15:8]),
                 dim_channel(ink_res[7:0])};
    end
    out_ink_rgb_nxt   = s1_swap_r ? paper_res : ink_dim;
    out_paper_rgb_nxt = s1_swap_r ? ink_dim : paper_res;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_ink_rgb_r   <= out_ink_rgb_nxt;
      out_paper_rgb_r <= out_paper_rgb_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ink_rgb   = out_ink_rgb_r;
  assign out_paper_rgb = out_paper_rgb_r;

  `ASSERT_CLK(a_s1_from_resolve, s1_valid_r |-> $past(accept && (in_operation == ccr_pkg::OP_RESOLVE)), "stage without resolve")
  `ASSERT_CLK(a_out_from_s1, out_valid_r |-> $past(s1_valid_r), "result without stage 1")
  `ASSERT_CLK(a_busy_stays_low, !busy_r |=> !busy_r, "busy rose outside reset")

endmodule
